// ===== hw/rtl/multi_stream_audio_mixer_unit_defines.svh =====
// assertion macros for the mixer rtl
// no dependencies
`ifndef MULTI_STREAM_AUDIO_MIXER_UNIT_DEFINES_SVH
`define MULTI_STREAM_AUDIO_MIXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSAM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define MSAM_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSAM_ASSERT(label, clk, rst_n, prop)
`define MSAM_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/msam_pkg.sv =====
// package for the multi stream audio mixer
// types, constants and opcodes used by the mixer unit
package msam_pkg;
	localparam int NumStreams = 8;
	localparam int RingDepth = 2048;
	localparam int MixChunk = 32;
	localparam int SidW = 3;
	localparam int PtrW = $clog2(RingDepth) + 1;
	localparam int AddrW = $clog2(NumStreams * RingDepth);
	localparam int ChunkW = $clog2(MixChunk + 1);
	localparam int AccW = 21;
	localparam logic [15:0] DefaultFrame = 16'd512;
	localparam logic [15:0] TimeoutReset = 16'd100;

	typedef enum logic [2:0] {
		OP_ACQUIRE = 3'd0,
		OP_RELEASE = 3'd1,
		OP_PUSH = 3'd2,
		OP_LIVE = 3'd3,
		OP_POP = 3'd4,
		OP_TICK = 3'd5,
		OP_CLEAR = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		KIND_MIX = 2'd0,
		KIND_CREDIT = 2'd1,
		KIND_ACQUIRE = 2'd2,
		KIND_PUSH = 2'd3
	} kind_t;
endpackage

// ===== hw/rtl/multi_stream_audio_mixer_unit.sv =====
// channel     dir  handshake       payload
// in          in   valid / stall   operation stream_id sample frame_size request_count
// out         out  valid / stall   kind mixed_sample slot credit_count ok last
// cfg         in   valid / ready   cfg_data (idle timeout)
// an item with a result holds off new items until its result is taken;
// a pop that mixes nothing ends after the slot scan, else it scans the slots, then per
// slot reads and accumulates each sample taken and counts its credits, then emits each
// mixed sample, steps through the credit items and ends in a final wait step.
// reset clears all slot state; ring data is undefined until written.
// out stall holds the finishing sequencer step.
// depends on msam_pkg, msam_ram and the defines header
`include "multi_stream_audio_mixer_unit_defines.svh"
module multi_stream_audio_mixer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [2:0]  stream_id,
	input  logic signed [17:0] sample,
	input  logic [15:0] frame_size,
	input  logic [15:0] request_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic signed [15:0] mixed_sample,
	output logic [2:0]  slot,
	output logic [6:0]  credit_count,
	output logic        ok,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import msam_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SLOT, S_READ, S_ACC, S_CRED, S_MIXRD, S_MIXOUT,
		S_CREDOUT, S_WAIT
	} state_t;

	state_t state_q;
	logic [PtrW-1:0] wr_q [NumStreams];
	logic [PtrW-1:0] rd_q [NumStreams];
	logic [NumStreams-1:0] use_q;
	logic [15:0] fsz_q [NumStreams];
	logic [16:0] cons_q [NumStreams];
	logic [31:0] lat_q [NumStreams];
	logic [31:0] now_q;
	logic [15:0] tmo_q;
	logic [SidW-1:0] s_q;
	logic [ChunkW-1:0] limit_q, i_q, take_q;
	logic any_q;
	logic [NumStreams-1:0] gave_q;
	logic [6:0] cred_q [NumStreams];
	logic [PtrW-1:0] held_v;

	// ring ram
	logic ring_we;
	logic [AddrW-1:0] ring_waddr, ring_raddr;
	logic [17:0] ring_rdata;
	// accumulator ram
	logic acc_we;
	logic [ChunkW-1:0] acc_waddr, acc_raddr;
	logic [AccW-1:0] acc_wdata, acc_rdata;

	msam_ram #(.Width(18), .Depth(NumStreams * RingDepth)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(sample),
		.raddr(ring_raddr), .rdata(ring_rdata));
	msam_ram #(.Width(AccW), .Depth(1 << ChunkW)) u_acc (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rdata));

	function automatic logic [PtrW-1:0] held_f(logic [PtrW-1:0] w, logic [PtrW-1:0] r);
		logic [PtrW-1:0] u;
		u = w - r;
		return (u > PtrW'(RingDepth)) ? PtrW'(RingDepth) : u;
	endfunction

	logic in_go;
	assign in_go = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign held_v = held_f(wr_q[s_q], rd_q[s_q]);

	logic [ChunkW-1:0] held_c;
	assign held_c = (held_v < PtrW'(limit_q)) ? ChunkW'(held_v) : limit_q;

	// ring addressing and push path
	logic [SidW-1:0] op_sid;
	logic push_ok;
	assign op_sid = stream_id;
	assign push_ok = held_f(wr_q[op_sid], rd_q[op_sid]) < PtrW'(RingDepth);
	assign ring_we = in_go && (op_t'(operation) == OP_PUSH) && push_ok;
	assign ring_waddr = AddrW'({op_sid, wr_q[op_sid][PtrW-2:0]});
	assign ring_raddr = AddrW'({s_q, rd_q[s_q][PtrW-2:0]});

	// accumulate: data for index i_q arrives with the acc read in the next cycle
	logic [SidW-1:0] first_q;
	logic signed [AccW-1:0] acc_old;
	assign acc_old = (s_q == first_q) ? '0 : acc_rdata;
	logic [ChunkW-1:0] ai_q;
	assign acc_we = (state_q == S_ACC);
	assign acc_waddr = ai_q;
	assign acc_wdata = AccW'(acc_old + AccW'($signed(ring_rdata)));
	assign acc_raddr = i_q;

	// output scaling
	logic signed [AccW-1:0] v_c;
	logic [16:0] mag_c;
	logic [31:0] prod_c;
	logic [15:0] res_c;
	always_comb begin
		v_c = $signed(acc_rdata);
		if (v_c > 21'sd32768) v_c = 21'sd32768;
		if (v_c < -21'sd32768) v_c = -21'sd32768;
		mag_c = v_c[AccW-1] ? 17'(-v_c) : 17'(v_c);
		prod_c = 32'(mag_c) * 32'd32767;
		res_c = v_c[AccW-1] ? 16'(-prod_c[30:15]) : prod_c[30:15];
	end

	logic first_empty_found;
	logic [SidW-1:0] first_empty;
	always_comb begin
		first_empty_found = 1'b0;
		first_empty = '0;
		for (int k = NumStreams - 1; k >= 0; k--) begin
			if (!use_q[k]) begin
				first_empty_found = 1'b1;
				first_empty = SidW'(k);
			end
		end
	end

	logic idle_c;
	assign idle_c = (now_q - lat_q[s_q]) > 32'(tmo_q);

	// a new result item is loaded this cycle
	logic out_load;
	assign out_load = (in_go && (op_t'(operation) == OP_ACQUIRE
			|| op_t'(operation) == OP_PUSH))
		|| (state_q == S_MIXOUT && (!out_valid || !out_stall))
		|| (state_q == S_CREDOUT && (!out_valid || !out_stall) && gave_q[s_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			use_q <= '0;
			now_q <= '0;
			tmo_q <= TimeoutReset;
			out_valid <= 1'b0;
			s_q <= '0;
			first_q <= '0;
			limit_q <= '0;
			i_q <= '0;
			ai_q <= '0;
			take_q <= '0;
			any_q <= 1'b0;
			gave_q <= '0;
			kind <= '0;
			mixed_sample <= '0;
			slot <= '0;
			credit_count <= '0;
			ok <= 1'b0;
			last <= 1'b0;
			for (int k = 0; k < NumStreams; k++) begin
				wr_q[k] <= '0;
				rd_q[k] <= '0;
				fsz_q[k] <= '0;
				cons_q[k] <= '0;
				lat_q[k] <= '0;
				cred_q[k] <= '0;
			end
		end else begin
			if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) tmo_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_go) begin
						unique case (op_t'(operation))
							OP_ACQUIRE: begin
								kind <= KIND_ACQUIRE;
								mixed_sample <= '0;
								credit_count <= '0;
								last <= 1'b1;
								ok <= first_empty_found;
								slot <= first_empty_found ? first_empty : '0;
								out_valid <= 1'b1;
								if (first_empty_found) begin
									use_q[first_empty] <= 1'b1;
									rd_q[first_empty] <= wr_q[first_empty];
									fsz_q[first_empty] <= (frame_size == '0) ? DefaultFrame
										: frame_size;
									cons_q[first_empty] <= '0;
									lat_q[first_empty] <= now_q;
								end
							end
							OP_RELEASE: begin
								rd_q[op_sid] <= wr_q[op_sid];
								use_q[op_sid] <= 1'b0;
							end
							OP_PUSH: begin
								kind <= KIND_PUSH;
								mixed_sample <= '0;
								credit_count <= '0;
								last <= 1'b1;
								ok <= push_ok;
								slot <= op_sid;
								out_valid <= 1'b1;
								if (push_ok) wr_q[op_sid] <= wr_q[op_sid] + 1'b1;
							end
							OP_LIVE: lat_q[op_sid] <= now_q;
							OP_POP: begin
								if (request_count != '0) begin
									limit_q <= (request_count < 16'(MixChunk))
										? ChunkW'(request_count) : ChunkW'(MixChunk);
									s_q <= '0;
									any_q <= 1'b0;
									gave_q <= '0;
									state_q <= S_SCAN;
								end
							end
							OP_TICK: now_q <= now_q + 32'd1;
							OP_CLEAR: begin
								for (int k = 0; k < NumStreams; k++) begin
									rd_q[k] <= wr_q[k];
									cons_q[k] <= '0;
								end
							end
							OP_NONE: ;
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (use_q[s_q] && !(idle_c && held_v == '0)) begin
						any_q <= 1'b1;
						if (held_v < PtrW'(limit_q)) limit_q <= ChunkW'(held_v);
					end
					if (s_q == SidW'(NumStreams - 1)) begin
						state_q <= S_SLOT;
						s_q <= '0;
						first_q <= '0;
					end else begin
						s_q <= s_q + 1'b1;
					end
				end
				S_SLOT: begin
					if (!any_q || limit_q == '0) begin
						state_q <= S_IDLE;
					end else if (use_q[s_q] && held_c != '0) begin
						take_q <= held_c;
						i_q <= '0;
						state_q <= S_READ;
					end else begin
						state_q <= S_CRED;
					end
				end
				S_READ: begin
					// ring read issued at the slot's read pointer, acc read for index i_q
					ai_q <= i_q;
					rd_q[s_q] <= rd_q[s_q] + 1'b1;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (ai_q + 1'b1 == take_q) begin
						gave_q[s_q] <= 1'b1;
						cons_q[s_q] <= cons_q[s_q] + 17'(take_q);
						cred_q[s_q] <= '0;
						state_q <= S_CRED;
					end else begin
						i_q <= ai_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_CRED: begin
					if (gave_q[s_q] && cons_q[s_q] >= 17'(fsz_q[s_q]) && fsz_q[s_q] != '0) begin
						cons_q[s_q] <= cons_q[s_q] - 17'(fsz_q[s_q]);
						cred_q[s_q] <= cred_q[s_q] + 1'b1;
					end else begin
						if (gave_q[s_q] && first_q == s_q) first_q <= first_q;
						if (s_q == SidW'(NumStreams - 1)) begin
							s_q <= '0;
							i_q <= '0;
							state_q <= S_MIXRD;
						end else begin
							s_q <= s_q + 1'b1;
							state_q <= S_SLOT;
						end
					end
				end
				S_MIXRD: begin
					state_q <= S_MIXOUT;
				end
				S_MIXOUT: begin
					if (!out_valid || !out_stall) begin
						kind <= KIND_MIX;
						mixed_sample <= res_c;
						slot <= '0;
						credit_count <= '0;
						ok <= 1'b0;
						last <= (i_q + 1'b1 == limit_q) && (gave_q == '0);
						out_valid <= 1'b1;
						if (i_q + 1'b1 == limit_q) begin
							s_q <= '0;
							state_q <= S_CREDOUT;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_MIXRD;
						end
					end
				end
				S_CREDOUT: begin
					if (!out_valid || !out_stall) begin
						if (gave_q[s_q]) begin
							kind <= KIND_CREDIT;
							mixed_sample <= '0;
							slot <= s_q;
							credit_count <= cred_q[s_q];
							ok <= 1'b0;
							last <= ((gave_q >> s_q) == NumStreams'(1));
							out_valid <= 1'b1;
						end
						if (s_q == SidW'(NumStreams - 1)) begin
							state_q <= S_WAIT;
						end else begin
							s_q <= s_q + 1'b1;
						end
					end
				end
				S_WAIT: begin
					if (!out_valid || !out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_SLOT && !(use_q[s_q] && held_c != '0) && first_q == s_q)
				first_q <= SidW'(s_q + 1'b1);
		end
	end

	`MSAM_ASSERT(a_busy_stalls, clk, arst_n, (state_q != S_IDLE) |-> in_stall)
	`MSAM_ASSERT(a_take_bound, clk, arst_n, (state_q == S_ACC) |-> (ai_q < take_q))
	`MSAM_ASSERT(a_cfg_idle, clk, arst_n, cfg_ready |-> (state_q == S_IDLE))
endmodule

// ===== hw/rtl/msam_ram.sv =====
// generic single port write, single port registered read ram
// no dependencies
module msam_ram #(
	parameter int Width = 18,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
